/* design/assert_macros.svh */
// Assertion macros for the quaternion ALU.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define QALU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define QALU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/qalu_pkg.sv */
// Shared types and constants of the quaternion ALU.
// No dependencies.
package qalu_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_MUL   = 3'd1,
		CMD_SCALE = 3'd2,
		CMD_CONJ  = 3'd3,
		CMD_DOT   = 3'd4,
		CMD_MAG   = 3'd5,
		CMD_NORM  = 3'd6,
		CMD_INV   = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic want_root;
		logic want_div;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Hamilton product: row r, term t -> operand indexes and sign
	localparam logic [1:0] HAM_A [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd2, 2'd3, 2'd1,
		2'd0, 2'd3, 2'd1, 2'd2
	};
	localparam logic [1:0] HAM_B [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd2, 2'd1
	};
	localparam logic HAM_NEG [16] = '{
		1'b0, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1
	};

endpackage

/* design/qalu_if.sv */
// Job and result channel interfaces of the quaternion ALU.
// No dependencies.
interface qalu_job_if #(parameter int W = 16);
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [W-1:0] a_w;
	logic signed [W-1:0] a_x;
	logic signed [W-1:0] a_y;
	logic signed [W-1:0] a_z;
	logic signed [W-1:0] b_w;
	logic signed [W-1:0] b_x;
	logic signed [W-1:0] b_y;
	logic signed [W-1:0] b_z;
	logic signed [W-1:0] scale_factor;

	modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		scale_factor, input ready);
	modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		scale_factor, output ready);
endinterface

interface qalu_res_if #(parameter int W = 16);
	logic               valid;
	logic               ready;
	logic signed [W-1:0] r_w;
	logic signed [W-1:0] r_x;
	logic signed [W-1:0] r_y;
	logic signed [W-1:0] r_z;
	logic               saturated;
	logic               divide_by_zero;

	modport source (output valid, r_w, r_x, r_y, r_z, saturated, divide_by_zero,
		input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, saturated, divide_by_zero,
		output ready);
endinterface

/* design/qalu_front.sv */
// Front end: takes job beats, classifies the command, feeds the queue.
// Uses qalu_pkg and qalu_job_if.
module qalu_front #(
	parameter int W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	qalu_job_if.sink          job,
	input  logic              full,
	output logic              push,
	output logic [$bits(qalu_pkg::ctl_t)+9*W-1:0] push_data
);
	localparam int PW = $bits(qalu_pkg::ctl_t) + 9 * W;

	qalu_pkg::ctl_t  ctl_c;
	logic            vld_s1;
	logic [PW-1:0]   data_s1;

	always_comb begin
		ctl_c.cmd       = qalu_pkg::cmd_t'(job.command);
		ctl_c.want_root = 1'b0;
		ctl_c.want_div  = 1'b0;
		case (ctl_c.cmd)
			qalu_pkg::CMD_MAG: begin
				ctl_c.want_root = 1'b1;
			end
			qalu_pkg::CMD_NORM: begin
				ctl_c.want_root = 1'b1;
				ctl_c.want_div  = 1'b1;
			end
			qalu_pkg::CMD_INV: begin
				ctl_c.want_div  = 1'b1;
			end
			default: ;
		endcase
	end

	assign job.ready = !vld_s1 || !full;
	assign push      = vld_s1 && !full;
	assign push_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (job.ready) begin
			vld_s1 <= job.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && job.ready) begin
			data_s1 <= {ctl_c, job.a_w, job.a_x, job.a_y, job.a_z,
				job.b_w, job.b_x, job.b_y, job.b_z, job.scale_factor};
		end
	end
endmodule

/* design/qalu_fifo.sv */
// Short queue between front and back end.
// Uses qalu_pkg.
module qalu_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     pop_data,
	output qalu_pkg::fifo_stat_t stat
);
	localparam int AW = qalu_pkg::FIFO_AW;

	logic [WIDTH-1:0] mem_q [qalu_pkg::FIFO_DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign stat.full  = (cnt_q == (AW+1)'(qalu_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end
endmodule

/* design/qalu_div.sv */
// One lane of the pipelined divider: mag * 2^(2F) / den, saturated, signed.
// One quotient bit per stage; no dependencies.
module qalu_div #(
	parameter int W   = 16,
	parameter int F   = 12,
	parameter int DDW = 33
) (
	input  logic           clk,
	input  logic           ce,
	input  logic [W-1:0]   mag,
	input  logic           neg,
	input  logic [DDW-1:0] den,
	output logic [W-1:0]   q,
	output logic           sat
);
	localparam int NW   = W + 2 * F;
	localparam int HW   = NW - W - 1;
	localparam int CMPW = (HW > DDW) ? HW : DDW;

	logic [NW-1:0]  num;
	logic [HW-1:0]  hi;
	logic [W:0]     lo;
	logic           over_pre;

	logic [DDW-1:0] rem_sn  [W+2];
	logic [W:0]     quo_sn  [W+2];
	logic [W:0]     lo_sn   [W+2];
	logic [DDW-1:0] den_sn  [W+2];
	logic           neg_sn  [W+2];
	logic           over_sn [W+2];

	logic [W:0] lim;
	logic [W:0] qq;
	logic [W:0] qneg;
	logic       ovr;

	assign num      = {mag, {(2*F){1'b0}}};
	assign hi       = num[NW-1:W+1];
	assign lo       = num[W:0];
	assign over_pre = (CMPW'(hi) >= CMPW'(den));

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_sn[0]  <= DDW'(hi);
			quo_sn[0]  <= '0;
			lo_sn[0]   <= lo;
			den_sn[0]  <= den;
			neg_sn[0]  <= neg;
			over_sn[0] <= over_pre;
		end
	end

	for (genvar j = 0; j <= W; j++) begin : g_iter
		logic [DDW:0] t;
		logic         ge;
		assign t  = {rem_sn[j], lo_sn[j][W-j]};
		assign ge = (t >= {1'b0, den_sn[j]});
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_sn[j+1]  <= ge ? DDW'(t - {1'b0, den_sn[j]}) : DDW'(t);
				quo_sn[j+1]  <= {quo_sn[j][W-1:0], ge};
				lo_sn[j+1]   <= lo_sn[j];
				den_sn[j+1]  <= den_sn[j];
				neg_sn[j+1]  <= neg_sn[j];
				over_sn[j+1] <= over_sn[j];
			end
		end
	end

	assign lim  = {1'b0, neg_sn[W+1], {(W-1){!neg_sn[W+1]}}};
	assign ovr  = over_sn[W+1] || (quo_sn[W+1] > lim);
	assign qq   = ovr ? lim : quo_sn[W+1];
	assign qneg = (W+1)'(0) - qq;
	assign q    = neg_sn[W+1] ? qneg[W-1:0] : qq[W-1:0];
	assign sat  = ovr;
endmodule

/* design/qalu_back.sv */
// Back end: multiply, sum, root and divide pipeline with the result register.
// Uses qalu_pkg, qalu_res_if and qalu_div.
module qalu_back #(
	parameter int W = 16,
	parameter int F = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [$bits(qalu_pkg::ctl_t)+9*W-1:0] pop_data,
	input  qalu_pkg::fifo_stat_t stat,
	output logic                 pop,
	qalu_res_if.source           res
);
	localparam int CW       = $bits(qalu_pkg::ctl_t);
	localparam int PW       = CW + 9 * W;
	localparam int SQW_FULL = 2 * W + 1;
	localparam int SQW      = (SQW_FULL > 64) ? 64 : SQW_FULL;
	localparam int NI       = (SQW + 1) / 2;
	localparam int RW       = SQW + 2;
	localparam int DDW      = (2 * W + 1 > W + 1 + F) ? 2 * W + 1 : W + 1 + F;
	localparam int DL       = W + 2;

	localparam logic signed [2*W+1:0] WIDE_MAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [2*W+1:0] WIDE_MIN = {{(W+3){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0]          VAL_MAX  = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		qalu_pkg::ctl_t     ctl;
		logic [3:0][W-1:0]  a;
		logic [3:0][W-1:0]  res;
		logic               sat;
		logic [SQW-1:0]     s;
		logic               zero;
	} side_t;

	// {saturated, value}
	function automatic logic [W:0] clip_w(input logic signed [2*W+1:0] v);
		logic [W:0] r;
		if (v > WIDE_MAX) begin
			r = {1'b1, VAL_MAX};
		end else if (v < WIDE_MIN) begin
			r = {1'b1, ~VAL_MAX};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic            ce;
	logic            vld_out;
	qalu_pkg::ctl_t  ctl;
	logic [W-1:0]    a_u [4];
	logic [W-1:0]    b_u [4];
	logic [W-1:0]    s_u;

	assign ce  = !vld_out || res.ready;
	assign pop = !stat.empty && ce;
	assign ctl = qalu_pkg::ctl_t'(pop_data[PW-1 -: CW]);
	assign s_u = pop_data[W-1:0];

	for (genvar i = 0; i < 4; i++) begin : g_unpack
		assign a_u[i] = pop_data[PW-CW-1-i*W -: W];
		assign b_u[i] = pop_data[PW-CW-1-(4+i)*W -: W];
	end

	// stage 1: operand select, multiply, add and conjugate
	logic signed [W-1:0]   ma [16];
	logic signed [W-1:0]   mb [16];
	logic                  mneg [16];
	logic signed [2*W-1:0] prod_s1 [16];
	logic                  neg_s1 [16];
	logic [W:0]            add_c [4];
	logic [W:0]            conj_c [4];
	side_t                 side_c1;
	side_t                 side_s1;
	logic                  vld_s1;

	for (genvar k = 0; k < 16; k++) begin : g_mul
		localparam int R = k / 4;
		localparam int T = k % 4;
		always_comb begin
			ma[k]   = '0;
			mb[k]   = '0;
			mneg[k] = 1'b0;
			case (ctl.cmd)
				qalu_pkg::CMD_MUL: begin
					ma[k]   = a_u[qalu_pkg::HAM_A[k]];
					mb[k]   = b_u[qalu_pkg::HAM_B[k]];
					mneg[k] = qalu_pkg::HAM_NEG[k];
				end
				qalu_pkg::CMD_DOT: begin
					if (R == 0) begin
						ma[k] = a_u[T];
						mb[k] = b_u[T];
					end
				end
				qalu_pkg::CMD_SCALE: begin
					if (T == 0) begin
						ma[k] = a_u[R];
						mb[k] = s_u;
					end
				end
				qalu_pkg::CMD_MAG, qalu_pkg::CMD_NORM, qalu_pkg::CMD_INV: begin
					if (R == 0) begin
						ma[k] = a_u[T];
						mb[k] = a_u[T];
					end
				end
				default: ;
			endcase
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				prod_s1[k] <= ma[k] * mb[k];
				neg_s1[k]  <= mneg[k];
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_simple
		assign add_c[i]  = clip_w((2*W+2)'($signed(a_u[i])) + (2*W+2)'($signed(b_u[i])));
		assign conj_c[i] = clip_w(-(2*W+2)'($signed(a_u[i])));
	end

	always_comb begin
		side_c1     = '0;
		side_c1.ctl = ctl;
		for (int i = 0; i < 4; i++) begin
			side_c1.a[i] = a_u[i];
		end
		case (ctl.cmd)
			qalu_pkg::CMD_ADD: begin
				for (int i = 0; i < 4; i++) begin
					side_c1.res[i] = add_c[i][W-1:0];
				end
				side_c1.sat = add_c[0][W] | add_c[1][W] | add_c[2][W] | add_c[3][W];
			end
			qalu_pkg::CMD_CONJ: begin
				side_c1.res[0] = a_u[0];
				for (int i = 1; i < 4; i++) begin
					side_c1.res[i] = conj_c[i][W-1:0];
				end
				side_c1.sat = conj_c[1][W] | conj_c[2][W] | conj_c[3][W];
			end
			default: ;
		endcase
	end

	// stage 2: row sums
	logic signed [2*W+1:0] term [16];
	logic signed [2*W+1:0] rsum_s2 [4];
	side_t                 side_s2;
	logic                  vld_s2;

	for (genvar k = 0; k < 16; k++) begin : g_term
		assign term[k] = neg_s1[k] ? -(2*W+2)'(prod_s1[k]) : (2*W+2)'(prod_s1[k]);
	end

	for (genvar r = 0; r < 4; r++) begin : g_rsum
		always_ff @(posedge clk) begin
			if (ce) begin
				rsum_s2[r] <= (term[4*r] + term[4*r+1]) + (term[4*r+2] + term[4*r+3]);
			end
		end
	end

	// stage 3: truncating shift and clipping of products, sum of squares
	logic [W:0]     mclip [4];
	logic           s_hi;
	logic [SQW-1:0] s_sat;
	logic           mul_cmd;
	side_t          side_c3;
	side_t          side_s3;
	logic           vld_s3;

	for (genvar r = 0; r < 4; r++) begin : g_mclip
		assign mclip[r] = clip_w(rsum_s2[r] >>> F);
	end

	if (SQW < SQW_FULL) begin : g_s_sat
		assign s_hi = |rsum_s2[0][SQW_FULL-1:SQW];
	end else begin : g_s_fit
		assign s_hi = 1'b0;
	end

	assign s_sat   = s_hi ? '1 : rsum_s2[0][SQW-1:0];
	assign mul_cmd = (side_s2.ctl.cmd == qalu_pkg::CMD_MUL) ||
		(side_s2.ctl.cmd == qalu_pkg::CMD_SCALE) || (side_s2.ctl.cmd == qalu_pkg::CMD_DOT);

	always_comb begin
		side_c3 = side_s2;
		if (mul_cmd) begin
			for (int r = 0; r < 4; r++) begin
				side_c3.res[r] = mclip[r][W-1:0];
			end
			side_c3.sat = mclip[0][W] | mclip[1][W] | mclip[2][W] | mclip[3][W];
		end
		side_c3.s    = s_sat;
		side_c3.zero = (s_sat == '0);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1 <= side_c1;
			side_s2 <= side_s1;
			side_s3 <= side_c3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= !stat.empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// square root, one result bit per stage
	logic [RW-1:0] rt_n_sn    [NI+1];
	logic [RW-1:0] rt_r_sn    [NI+1];
	side_t         rt_side_sn [NI+1];
	logic          rt_vld_sn  [NI+1];

	assign rt_n_sn[0]    = RW'(side_s3.s);
	assign rt_r_sn[0]    = '0;
	assign rt_side_sn[0] = side_s3;
	assign rt_vld_sn[0]  = vld_s3;

	for (genvar j = 0; j < NI; j++) begin : g_root
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NI - 1 - j));
		logic [RW-1:0] trial;
		assign trial = rt_r_sn[j] + BIT;
		always_ff @(posedge clk) begin
			if (ce) begin
				if (rt_n_sn[j] >= trial) begin
					rt_n_sn[j+1] <= rt_n_sn[j] - trial;
					rt_r_sn[j+1] <= (rt_r_sn[j] >> 1) + BIT;
				end else begin
					rt_n_sn[j+1] <= rt_n_sn[j];
					rt_r_sn[j+1] <= rt_r_sn[j] >> 1;
				end
				rt_side_sn[j+1] <= rt_side_sn[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_sn[j+1] <= 1'b0;
			end else if (ce) begin
				rt_vld_sn[j+1] <= rt_vld_sn[j];
			end
		end
	end

	// magnitude result and divider feed
	logic [RW-1:0]  root;
	logic           mag_big;
	side_t          dv_side0;
	logic [DDW-1:0] den;
	logic           inv_cmd;

	side_t          dv_side_sn [DL+1];
	logic           dv_vld_sn  [DL+1];
	logic [W-1:0]   dq   [4];
	logic           dsat [4];

	assign root    = rt_r_sn[NI];
	assign mag_big = |root[W:W-1];
	assign inv_cmd = rt_side_sn[NI].ctl.want_div && !rt_side_sn[NI].ctl.want_root;
	assign den     = rt_side_sn[NI].ctl.want_root ? DDW'({root[W:0], {F{1'b0}}})
		: DDW'(rt_side_sn[NI].s);

	always_comb begin
		dv_side0 = rt_side_sn[NI];
		if (dv_side0.ctl.want_root && !dv_side0.ctl.want_div) begin
			dv_side0.res[0] = mag_big ? VAL_MAX : root[W-1:0];
			dv_side0.sat    = mag_big;
		end
	end

	assign dv_side_sn[0] = dv_side0;
	assign dv_vld_sn[0]  = rt_vld_sn[NI];

	for (genvar i = 0; i < 4; i++) begin : g_lane
		logic signed [W-1:0] av;
		logic                lneg;
		logic [W-1:0]        lmag;
		assign av   = $signed(rt_side_sn[NI].a[i]);
		assign lmag = av[W-1] ? W'(-av) : W'(av);
		if (i == 0) begin : g_real
			assign lneg = av[W-1];
		end else begin : g_vec
			assign lneg = inv_cmd ? (av > 0) : av[W-1];
		end
		qalu_div #(.W(W), .F(F), .DDW(DDW)) u_div (
			.clk (clk),
			.ce  (ce),
			.mag (lmag),
			.neg (lneg),
			.den (den),
			.q   (dq[i]),
			.sat (dsat[i])
		);
	end

	for (genvar j = 0; j < DL; j++) begin : g_dpipe
		always_ff @(posedge clk) begin
			if (ce) dv_side_sn[j+1] <= dv_side_sn[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sn[j+1] <= 1'b0;
			end else if (ce) begin
				dv_vld_sn[j+1] <= dv_vld_sn[j];
			end
		end
	end

	// result register
	logic [3:0][W-1:0] res_c;
	logic              sat_c;
	logic              dz_c;
	logic [W-1:0]      r_q [4];
	logic              sat_q;
	logic              dz_q;

	always_comb begin
		res_c = dv_side_sn[DL].res;
		sat_c = dv_side_sn[DL].sat;
		dz_c  = 1'b0;
		if (dv_side_sn[DL].ctl.want_div) begin
			if (dv_side_sn[DL].zero) begin
				res_c = '0;
				sat_c = 1'b0;
				dz_c  = 1'b1;
			end else begin
				for (int i = 0; i < 4; i++) begin
					res_c[i] = dq[i];
				end
				sat_c = dsat[0] | dsat[1] | dsat[2] | dsat[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++) begin
				r_q[i] <= res_c[i];
			end
			sat_q <= sat_c;
			dz_q  <= dz_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (ce) begin
			vld_out <= dv_vld_sn[DL];
		end
	end

	assign res.valid          = vld_out;
	assign res.r_w            = r_q[0];
	assign res.r_x            = r_q[1];
	assign res.r_y            = r_q[2];
	assign res.r_z            = r_q[3];
	assign res.saturated      = sat_q;
	assign res.divide_by_zero = dz_q;
endmodule

/* design/quaternion_alu_top.sv */
// Quaternion ALU in signed fixed point (Q4.12 by default): add, Hamilton product,
// scale, conjugate, dot, magnitude, normalize and inverse, one result per job beat.
// Accepts one beat per cycle while the result side does not stall. The back end holds
// a square root (one root bit per stage) and a divider (one quotient bit per stage).
// A four-beat queue between front and back end absorbs result-side stalls; the back
// end advances only when its result register is free.
// Depends on qalu_pkg, qalu_if, qalu_front, qalu_fifo, qalu_back and assert_macros.svh.
`include "assert_macros.svh"

module quaternion_alu_top #(
	parameter int DATA_WIDTH    = 16,
	parameter int FRACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	qalu_job_if.sink    job,
	qalu_res_if.source  res
);
	localparam int PW = $bits(qalu_pkg::ctl_t) + 9 * DATA_WIDTH;

	logic                 push;
	logic [PW-1:0]        push_data;
	logic                 pop;
	logic [PW-1:0]        pop_data;
	qalu_pkg::fifo_stat_t stat;

	qalu_front #(.W(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.full      (stat.full),
		.push      (push),
		.push_data (push_data)
	);

	qalu_fifo #(.WIDTH(PW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	qalu_back #(.W(DATA_WIDTH), .F(FRACTION_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.stat     (stat),
		.pop      (pop),
		.res      (res)
	);

	`QALU_ASSERT_ALWAYS(a_fifo_flags, !(stat.full && stat.empty), "queue full and empty")
	`QALU_ASSERT_IMPLY(a_no_overrun, push, !stat.full, "push into full queue")
	`QALU_ASSERT_IMPLY(a_no_underrun, pop, !stat.empty, "pop from empty queue")
	`QALU_ASSERT_NEXT(a_push_lands, push, !stat.empty, "pushed beat lost")
	`QALU_ASSERT_IMPLY(a_dz_clean, res.valid && res.divide_by_zero, res.r_w == 0 && res.r_x == 0 && res.r_y == 0 && res.r_z == 0 && !res.saturated, "divide by zero result not clean")
endmodule
